@@ src/pairwise_compatibility_weight_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef PAIRWISE_COMPATIBILITY_WEIGHT_DEFINES_SVH
`define PAIRWISE_COMPATIBILITY_WEIGHT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pcw_pkg.sv @@
package pcw_pkg;

	// Fixed field widths
	localparam int COORD_BITS      = 24;
	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int INDEX_W         = 10;
	localparam int MODE_W          = 2;
	localparam int RES_W           = 16;
	localparam int WEIGHT_W        = 17;
	localparam int CFG_W           = 17;
	localparam int CFG_IDX_W       = 2;

	// Distance datapath widths
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int ACC_W  = SQ_W + 2;
	localparam int ROOT_W = ACC_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int D2_W   = 2 * ROOT_W;

	// Kernel datapath widths
	localparam int RSQ_W     = 2 * RES_W;
	localparam int DEN_W     = RSQ_W + 8;
	localparam int QINT_W    = 4;
	localparam int FRAC_W    = 16;
	localparam int X_W       = QINT_W + FRAC_W;
	localparam int Y_SHIFT   = 10;
	localparam int Y_W       = X_W + Y_SHIFT;
	localparam int ONE_W     = 31;
	localparam int SS_W      = ONE_W + 2;
	localparam int RCP_W     = 33;
	localparam int TERMS     = 12;
	localparam int SQUARINGS = 4;
	localparam int ROUND_SH  = 14;

	localparam logic [ONE_W-1:0] ONE_Q30 = ONE_W'(1) << 30;

	// Controller sequencing
	localparam int CNT_W  = $clog2(ROOT_W);
	localparam int STEP_W = 4;

	// Codes
	localparam logic       CMD_LOAD   = 1'b0;
	localparam logic       CMD_QUERY  = 1'b1;
	localparam logic [1:0] MODE_DIST  = 2'd0;
	localparam logic [1:0] MODE_SCORE = 2'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE,
		CFG_RESOLUTION,
		CFG_DIST_LIMIT,
		CFG_SCORE_LIMIT
	} pcw_cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_RD_A, ST_RD_B, ST_SQ, ST_ROOT_INIT, ST_ROOT,
		ST_DIFF, ST_SQ_D, ST_DIV_INIT, ST_DIV, ST_SER_INIT, ST_SER_MUL,
		ST_SER_RCP, ST_SER_FIX, ST_CLAMP, ST_POW, ST_EMIT
	} pcw_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CAPTURE, OP_READ_A, OP_READ_B, OP_SQ, OP_ROOT_INIT, OP_ROOT,
		OP_DIFF, OP_SQ_D, OP_DIV_INIT, OP_DIV, OP_SER_INIT, OP_SER_MUL,
		OP_SER_RCP, OP_SER_FIX, OP_CLAMP, OP_POW, OP_EMIT
	} pcw_op_t;

	typedef struct packed {
		pcw_op_t           op;
		logic [STEP_W-1:0] step;
	} pcw_cmd_t;

	typedef struct packed {
		logic load;
		logic skip;
	} pcw_status_t;

	typedef struct packed {
		logic                         command;
		logic [INDEX_W-1:0]           index_a;
		logic [INDEX_W-1:0]           index_b;
		logic signed [COORD_BITS-1:0] src_x;
		logic signed [COORD_BITS-1:0] src_y;
		logic signed [COORD_BITS-1:0] src_z;
		logic signed [COORD_BITS-1:0] des_x;
		logic signed [COORD_BITS-1:0] des_y;
		logic signed [COORD_BITS-1:0] des_z;
	} pcw_in_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                kept;
	} pcw_out_t;

	// floor(2^32 / n) for the series term divisor n
	function automatic logic [RCP_W-1:0] term_recip(input logic [STEP_W-1:0] n);
		case (n)
			4'd1:    return 33'h1_0000_0000;
			4'd2:    return 33'h0_8000_0000;
			4'd3:    return 33'h0_5555_5555;
			4'd4:    return 33'h0_4000_0000;
			4'd5:    return 33'h0_3333_3333;
			4'd6:    return 33'h0_2AAA_AAAA;
			4'd7:    return 33'h0_2492_4924;
			4'd8:    return 33'h0_2000_0000;
			4'd9:    return 33'h0_1C71_C71C;
			4'd10:   return 33'h0_1999_9999;
			4'd11:   return 33'h0_1745_D174;
			4'd12:   return 33'h0_1555_5555;
			default: return '0;
		endcase
	endfunction

endpackage

@@ src/pairwise_compatibility_weight.sv @@
// Query: a result strobe follows the start transfer; start is ignored while busy.
// The sequence runs the 26-step square root, the 20-step divider and 12 series terms.
// Load: no result. Query on equal slots or mode 2/3: the sequencer goes from decode
// straight to emit. Results are shown for one cycle only; the receiver cannot stall.
// Reset clears the sequencer, the strobe and the configuration registers to their
// defaults; the point stores are not cleared and read as undefined until written.
module pairwise_compatibility_weight import pcw_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pcw_in_t              item,
	output logic                 done,
	output pcw_out_t             result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	pcw_cmd_t    cmd;
	pcw_status_t status;

	pcw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.busy  (busy),
		.cmd   (cmd)
	);

	pcw_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (cmd),
		.status   (status),
		.done     (done),
		.result   (result)
	);

endmodule

@@ src/pcw_ram.sv @@
module pcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/pcw_ctrl.sv @@
module pcw_ctrl import pcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  pcw_status_t status,
	output logic        busy,
	output pcw_cmd_t    cmd
);

	pcw_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// Sequence one item through the datapath
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd.op   = OP_NONE;
		cmd.step = cnt_q[STEP_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.load) begin
					state_d = ST_IDLE;
				end else if (status.skip) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_RD_A;
				end
			end
			ST_RD_A: begin
				cmd.op  = OP_READ_A;
				state_d = ST_RD_B;
			end
			ST_RD_B: begin
				cmd.op  = OP_READ_B;
				cnt_d   = '0;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.op = OP_SQ;
				if (cnt_q == CNT_W'(2)) begin
					state_d = ST_ROOT_INIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ROOT_INIT: begin
				cmd.op  = OP_ROOT_INIT;
				cnt_d   = '0;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.op = OP_ROOT;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					state_d = ST_DIFF;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = ST_SQ_D;
			end
			ST_SQ_D: begin
				cmd.op  = OP_SQ_D;
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.op  = OP_DIV_INIT;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				if (cnt_q == CNT_W'(X_W - 1)) begin
					state_d = ST_SER_INIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SER_INIT: begin
				cmd.op  = OP_SER_INIT;
				cnt_d   = CNT_W'(1);
				state_d = ST_SER_MUL;
			end
			ST_SER_MUL: begin
				cmd.op  = OP_SER_MUL;
				state_d = ST_SER_RCP;
			end
			ST_SER_RCP: begin
				cmd.op  = OP_SER_RCP;
				state_d = ST_SER_FIX;
			end
			ST_SER_FIX: begin
				cmd.op = OP_SER_FIX;
				if (cnt_q == CNT_W'(TERMS)) begin
					state_d = ST_CLAMP;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = ST_SER_MUL;
				end
			end
			ST_CLAMP: begin
				cmd.op  = OP_CLAMP;
				cnt_d   = '0;
				state_d = ST_POW;
			end
			ST_POW: begin
				cmd.op = OP_POW;
				if (cnt_q == CNT_W'(SQUARINGS - 1)) begin
					state_d = ST_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_EMIT: begin
				cmd.op  = OP_EMIT;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/pcw_dp.sv @@
module pcw_dp import pcw_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  pcw_in_t              item,
	input  pcw_cmd_t             cmd,
	output pcw_status_t          status,
	output logic                 done,
	output pcw_out_t             result
);

	localparam int AW      = $clog2(MAX_ENTRIES);
	localparam int PT_W    = 3 * COORD_BITS;
	localparam int WRAP_SH = 2 * INDEX_W;
	localparam int RECIP_W = WRAP_SH + 1;
	localparam bit WRAP    = (MAX_ENTRIES < (1 << INDEX_W));
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << WRAP_SH) / MAX_ENTRIES + 1);

	// Slot number modulo the store depth, by reciprocal multiply
	function automatic logic [AW-1:0] wrap_index(input logic [INDEX_W-1:0] raw);
		logic [INDEX_W+RECIP_W-1:0] prod;
		logic [INDEX_W-1:0]         quo;
		logic [INDEX_W+AW-1:0]      back;
		logic [INDEX_W-1:0]         rem;
		prod = {{RECIP_W{1'b0}}, raw} * {{INDEX_W{1'b0}}, RECIP};
		quo  = prod[WRAP_SH +: INDEX_W];
		back = {{AW{1'b0}}, quo} * (INDEX_W + AW)'(MAX_ENTRIES);
		rem  = raw - back[INDEX_W-1:0];
		if (WRAP) begin
			return AW'(rem);
		end else begin
			return AW'(raw);
		end
	endfunction

	function automatic logic signed [COORD_BITS-1:0] coord_of(input logic [PT_W-1:0] w,
			input logic [1:0] k);
		return w[(2 - k) * COORD_BITS +: COORD_BITS];
	endfunction

	// Configuration registers
	logic [MODE_W-1:0]   mode_q;
	logic [RES_W-1:0]    res_q;
	logic [RES_W-1:0]    dlim_q;
	logic [WEIGHT_W-1:0] slim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DIST;
			res_q  <= RES_W'(655);
			dlim_q <= RES_W'(3277);
			slim_q <= WEIGHT_W'(58982);
		end else if (cfg_we) begin
			case (pcw_cfg_idx_t'(cfg_index))
				CFG_MODE:        mode_q <= cfg_data[MODE_W-1:0];
				CFG_RESOLUTION:  res_q  <= cfg_data[RES_W-1:0];
				CFG_DIST_LIMIT:  dlim_q <= cfg_data[RES_W-1:0];
				CFG_SCORE_LIMIT: slim_q <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Captured item
	logic          load_q;
	logic [AW-1:0] a_q, b_q;
	logic [AW-1:0] a_in;

	assign a_in = wrap_index(item.index_a);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			load_q <= (item.command == CMD_LOAD);
			a_q    <= a_in;
			b_q    <= wrap_index(item.index_b);
		end
	end

	assign status.load = load_q;
	assign status.skip = (a_q == b_q) || mode_q[1];

	// Point stores and distance lanes: lane 0 source, lane 1 target
	logic              we;
	logic [AW-1:0]     raddr;
	logic [PT_W-1:0]   wd   [2];
	logic [PT_W-1:0]   rd   [2];
	logic [ROOT_W-1:0] root_q [2];

	assign we    = (cmd.op == OP_CAPTURE) && (item.command == CMD_LOAD);
	assign raddr = (cmd.op == OP_READ_A) ? a_q : b_q;
	assign wd[0] = {item.src_x, item.src_y, item.src_z};
	assign wd[1] = {item.des_x, item.des_y, item.des_z};

	for (genvar ln = 0; ln < 2; ln++) begin : g_lane
		logic [PT_W-1:0]          pa_q;
		logic [ACC_W-1:0]         acc_q;
		logic [ACC_W-1:0]         rv_q;
		logic [REM_W-1:0]         rem_q;
		logic signed [DIFF_W-1:0] df;
		logic [DIFF_W-1:0]        mag;
		logic [SQ_W-1:0]          sq;
		logic [REM_W+1:0]         rem_sh;
		logic [REM_W+1:0]         sub;

		pcw_ram #(.WIDTH(PT_W), .DEPTH(MAX_ENTRIES)) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(a_in),
			.wdata(wd[ln]),
			.raddr(raddr),
			.rdata(rd[ln])
		);

		// Square of one axis difference
		always_comb begin
			df  = DIFF_W'(coord_of(pa_q, cmd.step[1:0]))
				- DIFF_W'(coord_of(rd[ln], cmd.step[1:0]));
			mag = df[DIFF_W-1] ? DIFF_W'(-df) : DIFF_W'(df);
			sq  = SQ_W'(mag) * SQ_W'(mag);
		end

		// One root digit per step
		assign rem_sh = {rem_q, rv_q[ACC_W-1 -: 2]};
		assign sub    = (REM_W + 2)'({root_q[ln], 2'b01});

		always_ff @(posedge clk) begin
			case (cmd.op)
				OP_READ_B: begin
					pa_q <= rd[ln];
				end
				OP_SQ: begin
					if (cmd.step == '0) begin
						acc_q <= ACC_W'(sq);
					end else begin
						acc_q <= acc_q + ACC_W'(sq);
					end
				end
				OP_ROOT_INIT: begin
					rv_q       <= acc_q;
					rem_q      <= '0;
					root_q[ln] <= '0;
				end
				OP_ROOT: begin
					rv_q <= rv_q << 2;
					if (rem_sh >= sub) begin
						rem_q      <= REM_W'(rem_sh - sub);
						root_q[ln] <= {root_q[ln][ROOT_W-2:0], 1'b1};
					end else begin
						rem_q      <= REM_W'(rem_sh);
						root_q[ln] <= {root_q[ln][ROOT_W-2:0], 1'b0};
					end
				end
				default: ;
			endcase
		end
	end

	// Kernel argument: d, d^2, den, and d^2 * 2^16 / den
	logic [ROOT_W-1:0] d_q;
	logic [RSQ_W-1:0]  rsq_q;
	logic [D2_W-1:0]   d2_q;
	logic [DEN_W-1:0]  den_q;
	logic              zero_q;
	logic [DEN_W-1:0]  dr_q;
	logic [X_W-1:0]    dbits_q;
	logic [X_W-1:0]    x_q;
	logic [RES_W-1:0]  res_eff;
	logic [DEN_W:0]    r2;

	assign res_eff = (res_q == '0) ? RES_W'(1) : res_q;
	assign r2      = {dr_q, dbits_q[X_W-1]};

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DIFF: begin
				d_q   <= (root_q[0] >= root_q[1]) ? root_q[0] - root_q[1]
					: root_q[1] - root_q[0];
				rsq_q <= RSQ_W'(res_eff) * RSQ_W'(res_eff);
			end
			OP_SQ_D: begin
				d2_q  <= D2_W'(d_q) * D2_W'(d_q);
				den_q <= (DEN_W'(rsq_q) << 7) + (DEN_W'(rsq_q) << 6) + (DEN_W'(rsq_q) << 3);
			end
			OP_DIV_INIT: begin
				zero_q  <= (d2_q >= (D2_W'(den_q) << QINT_W));
				dr_q    <= d2_q[QINT_W +: DEN_W];
				dbits_q <= {d2_q[QINT_W-1:0], {FRAC_W{1'b0}}};
				x_q     <= '0;
			end
			OP_DIV: begin
				dbits_q <= dbits_q << 1;
				if (r2 >= {1'b0, den_q}) begin
					dr_q <= DEN_W'(r2 - {1'b0, den_q});
					x_q  <= {x_q[X_W-2:0], 1'b1};
				end else begin
					dr_q <= r2[DEN_W-1:0];
					x_q  <= {x_q[X_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// Series for exp(-x/16), then four squarings
	logic [Y_W-1:0]           y_q;
	logic [ONE_W-1:0]         t_q;
	logic [ONE_W-1:0]         p_q;
	logic [ONE_W-1:0]         q0_q;
	logic signed [SS_W-1:0]   ssum_q;
	logic [ONE_W-1:0]         s_q;
	logic [ONE_W+Y_W-1:0]     prod_ty;
	logic [ONE_W+RCP_W-1:0]   prod_pr;
	logic [ONE_W+STEP_W-1:0]  back;
	logic [ONE_W-1:0]         r_fix;
	logic [ONE_W-1:0]         tn;
	logic [2*ONE_W-1:0]       prod_ss;

	always_comb begin
		prod_ty = (ONE_W + Y_W)'(t_q) * (ONE_W + Y_W)'(y_q);
		prod_pr = (ONE_W + RCP_W)'(p_q) * (ONE_W + RCP_W)'(term_recip(cmd.step));
		back    = (ONE_W + STEP_W)'(q0_q) * (ONE_W + STEP_W)'(cmd.step);
		r_fix   = p_q - back[ONE_W-1:0];
		tn      = (r_fix >= ONE_W'(cmd.step)) ? q0_q + 1'b1 : q0_q;
		prod_ss = (2 * ONE_W)'(s_q) * (2 * ONE_W)'(s_q);
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SER_INIT: begin
				y_q    <= {x_q, {Y_SHIFT{1'b0}}};
				t_q    <= ONE_Q30;
				ssum_q <= $signed({2'b00, ONE_Q30});
			end
			OP_SER_MUL: begin
				p_q <= prod_ty[30 +: ONE_W];
			end
			OP_SER_RCP: begin
				q0_q <= prod_pr[32 +: ONE_W];
			end
			OP_SER_FIX: begin
				t_q <= tn;
				if (cmd.step[0]) begin
					ssum_q <= ssum_q - $signed({2'b00, tn});
				end else begin
					ssum_q <= ssum_q + $signed({2'b00, tn});
				end
			end
			OP_CLAMP: begin
				if (ssum_q[SS_W-1]) begin
					s_q <= '0;
				end else if (ssum_q > $signed({2'b00, ONE_Q30})) begin
					s_q <= ONE_Q30;
				end else begin
					s_q <= ssum_q[ONE_W-1:0];
				end
			end
			OP_POW: begin
				s_q <= prod_ss[30 +: ONE_W];
			end
			default: ;
		endcase
	end

	// Round, apply the mode's test, register the result and strobe done for one cycle
	logic [ONE_W:0]      s_rnd;
	logic [WEIGHT_W-1:0] w;
	logic                keep;

	always_comb begin
		s_rnd = {1'b0, s_q} + (ONE_W + 1)'(1 << (ROUND_SH - 1));
		w     = zero_q ? '0 : s_rnd[ROUND_SH +: WEIGHT_W];
		if (status.skip) begin
			keep = 1'b0;
		end else if (mode_q == MODE_SCORE) begin
			keep = (w > slim_q);
		end else begin
			keep = (d_q <= ROOT_W'(dlim_q));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			result.weight <= keep ? w : '0;
			result.kept   <= keep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (cmd.op == OP_EMIT);
		end
	end

endmodule

@@ src/pcw_checker.sv @@
`include "pairwise_compatibility_weight_defines.svh"

module pcw_checker import pcw_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input pcw_out_t result
);

	// An accepted transfer always occupies the block for the next cycle
	`PCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	// A result appears only once the block is idle again
	`PCW_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
	// Each result is strobed for a single cycle
	`PCW_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")
	// A dropped pair carries no weight
	`PCW_ASSERT_NOW(a_drop_zero, done && !result.kept, result.weight == '0, "weight on drop")
	// Weight never exceeds one in Q1.16
	`PCW_ASSERT_NOW(a_weight_max, done, result.weight <= 17'd65536, "weight above one")

endmodule

bind pairwise_compatibility_weight pcw_checker u_pcw_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
